// ===== sv/pxk_pkg.sv =====
// pxk_pkg: shared constants and types for the prefix xor k-th largest block
// used by prefix_xor_kth_largest, pxk_line and pxk_topk; depends on nothing
package pxk_pkg;

   // configuration register widths and port sizes
   localparam int NUM_COLS_W = 11;
   localparam int RANK_K_W   = 7;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   // register index codes, taken from paddr[2]
   localparam logic REG_NUM_COLS = 1'b0;
   localparam logic REG_RANK_K   = 1'b1;

   // control of the word that leaves the prefix stage
   typedef struct packed {
      logic valid;
      logic last;
   } stage_type;

endpackage

// ===== sv/prefix_xor_kth_largest.sv =====
// prefix_xor_kth_largest: top level with csr registers and the result queue
// depends on pxk_pkg, pxk_line and pxk_topk
//
// Matrix elements enter on the req channel in row-major order, one word per
// element: req_tdata carries the element, req_tlast marks the final element.
// For every element the block forms the xor of all elements above and to the
// left (inclusive) and keeps the MAX_RANK largest of those values. On the word
// marked last one result leaves on the rsp channel: the k-th largest value in
// rsp_tdata and in rsp_tuser whether at least k values were seen (else the
// value reads zero). The block then starts over for the next matrix.
// Throughput is one element per clock while req_tready is high; the prefix
// stage reads the line memory in the accept cycle and inserts into the cell
// row in the next one. A result passes the prefix stage register and is then
// written into the result queue, from which rsp_tvalid is raised.
// Results wait in a four-entry queue; when the receiver stalls, req_tready drops
// once three results are queued or in flight. Reset clears control state and
// the cell row at once, with no clearing pass; line memory entries hold junk
// until written by a row. num_cols and rank_k sit at csr addresses 0 and 4 and
// are to be written only while the block is idle; the block does not enforce it.
module prefix_xor_kth_largest #(
   parameter int MAX_COLS   = 1024,
   parameter int MAX_RANK   = 64,
   parameter int VALUE_BITS = 20
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // element_value
   input  logic [((VALUE_BITS+7)/8)*8-1:0] req_tdata,
   // last_element
   input  logic                            req_tlast,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // kth_value
   output logic [((VALUE_BITS+7)/8)*8-1:0] rsp_tdata,
   // rank_reached
   output logic                            rsp_tuser,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [pxk_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [pxk_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [pxk_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                            csr_pready
);

   localparam int TDATA_W  = ((VALUE_BITS + 7) / 8) * 8;
   localparam int OQ_DEPTH = 4;
   localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
   localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1);
   // one slot held back for a result still in the prefix stage
   localparam int OQ_LIMIT = OQ_DEPTH - 2;

   logic [pxk_pkg::NUM_COLS_W-1:0] num_cols_ff;
   logic [pxk_pkg::RANK_K_W-1:0]   rank_k_ff;
   logic                           csr_write;

   logic                           in_accept;
   pxk_pkg::stage_type             stage;
   logic [VALUE_BITS-1:0]          prefix;
   logic                           res_valid;
   logic [VALUE_BITS-1:0]          res_value;
   logic                           res_reached;

   logic [VALUE_BITS-1:0]          oq_value_ff   [OQ_DEPTH];
   logic                           oq_reached_ff [OQ_DEPTH];
   logic [OQ_PTR_W-1:0]            wr_ptr_ff;
   logic [OQ_PTR_W-1:0]            rd_ptr_ff;
   logic [OQ_CNT_W-1:0]            count_ff;
   logic [OQ_CNT_W-1:0]            count_in;
   logic [OQ_CNT_W-1:0]            pending;
   logic                           pop;

   // csr registers
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         num_cols_ff <= pxk_pkg::NUM_COLS_W'(1);
         rank_k_ff   <= pxk_pkg::RANK_K_W'(1);
      end else if (csr_write) begin
         unique case (csr_paddr[2])
            pxk_pkg::REG_NUM_COLS: num_cols_ff <= csr_pwdata[pxk_pkg::NUM_COLS_W-1:0];
            pxk_pkg::REG_RANK_K:   rank_k_ff   <= csr_pwdata[pxk_pkg::RANK_K_W-1:0];
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         pxk_pkg::REG_NUM_COLS: csr_prdata = pxk_pkg::CSR_DATA_W'(num_cols_ff);
         pxk_pkg::REG_RANK_K:   csr_prdata = pxk_pkg::CSR_DATA_W'(rank_k_ff);
      endcase
   end

   // input acceptance, held off while the result queue could overflow
   assign pending    = count_ff + OQ_CNT_W'(stage.valid && stage.last);
   assign req_tready = (pending <= OQ_CNT_W'(OQ_LIMIT));
   assign in_accept  = req_tvalid && req_tready;

   pxk_line #(
      .MAX_COLS   (MAX_COLS),
      .VALUE_BITS (VALUE_BITS)
   ) u_line (
      .clock     (clock),
      .reset     (reset),
      .in_accept (in_accept),
      .in_value  (req_tdata[VALUE_BITS-1:0]),
      .in_last   (req_tlast),
      .num_cols  (num_cols_ff),
      .out_stage (stage),
      .out_value (prefix)
   );

   pxk_topk #(
      .MAX_RANK   (MAX_RANK),
      .VALUE_BITS (VALUE_BITS)
   ) u_topk (
      .clock       (clock),
      .reset       (reset),
      .ins_stage   (stage),
      .ins_value   (prefix),
      .rank_k      (rank_k_ff),
      .res_valid   (res_valid),
      .res_value   (res_value),
      .res_reached (res_reached)
   );

   // result queue
   assign pop      = rsp_tvalid && rsp_tready;
   assign count_in = count_ff + OQ_CNT_W'(res_valid) - OQ_CNT_W'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (res_valid) begin
            wr_ptr_ff <= wr_ptr_ff + OQ_PTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + OQ_PTR_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid) begin
         oq_value_ff[wr_ptr_ff]   <= res_value;
         oq_reached_ff[wr_ptr_ff] <= res_reached;
      end
   end

   assign rsp_tvalid = (count_ff != '0);
   assign rsp_tdata  = TDATA_W'(oq_value_ff[rd_ptr_ff]);
   assign rsp_tuser  = oq_reached_ff[rd_ptr_ff];

endmodule

// ===== sv/pxk_line.sv =====
// pxk_line: column tracking, previous row line memory and 2d prefix xor stage
// depends on pxk_pkg
module pxk_line #(
   parameter int MAX_COLS   = 1024,
   parameter int VALUE_BITS = 20
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_accept,
   input  logic [VALUE_BITS-1:0]         in_value,
   input  logic                          in_last,
   input  logic [pxk_pkg::NUM_COLS_W-1:0] num_cols,
   output pxk_pkg::stage_type            out_stage,
   output logic [VALUE_BITS-1:0]         out_value
);

   localparam int COL_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int CNT_W = (COL_W + 1 > pxk_pkg::NUM_COLS_W) ? COL_W + 1 : pxk_pkg::NUM_COLS_W;

   logic [COL_W-1:0]      col_ff;
   logic [VALUE_BITS-1:0] rowxor_ff;
   logic                  first_ff;

   logic                  s1_valid_ff;
   logic                  s1_last_ff;
   logic                  s1_first_ff;
   logic [COL_W-1:0]      s1_col_ff;
   logic [VALUE_BITS-1:0] s1_rowxor_ff;

   logic                  byp_ff;
   logic [VALUE_BITS-1:0] byp_data_ff;
   logic [VALUE_BITS-1:0] mem_q_ff;
   logic [VALUE_BITS-1:0] line_mem [MAX_COLS];

   logic [CNT_W-1:0]      cols_ext;
   logic [CNT_W-1:0]      cols_lim;
   logic [CNT_W-1:0]      col_next;
   logic                  row_end;
   logic [VALUE_BITS-1:0] rowxor_in;
   logic [VALUE_BITS-1:0] above;
   logic [VALUE_BITS-1:0] prefix;

   // clamp column count to 1..MAX_COLS
   assign cols_ext = CNT_W'(num_cols);
   always_comb begin
      priority if (cols_ext == '0) begin
         cols_lim = CNT_W'(1);
      end else if (cols_ext > CNT_W'(MAX_COLS)) begin
         cols_lim = CNT_W'(MAX_COLS);
      end else begin
         cols_lim = cols_ext;
      end
   end

   assign col_next  = CNT_W'(col_ff) + CNT_W'(1);
   assign row_end   = (col_next >= cols_lim);
   assign rowxor_in = rowxor_ff ^ in_value;

   // row position and running xor of the current row
   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         rowxor_ff   <= '0;
         first_ff    <= 1'b1;
         s1_valid_ff <= 1'b0;
         byp_ff      <= 1'b0;
      end else begin
         s1_valid_ff <= in_accept;
         // same column written by the stage ahead at this edge: forward it
         byp_ff      <= s1_valid_ff && (s1_col_ff == col_ff);
         if (in_accept) begin
            priority if (in_last) begin
               col_ff    <= '0;
               rowxor_ff <= '0;
               first_ff  <= 1'b1;
            end else if (row_end) begin
               col_ff    <= '0;
               rowxor_ff <= '0;
               first_ff  <= 1'b0;
            end else begin
               col_ff    <= col_next[COL_W-1:0];
               rowxor_ff <= rowxor_in;
            end
         end
      end
   end

   // word held for the prefix stage
   always_ff @(posedge clock) begin
      byp_data_ff <= prefix;
      if (in_accept) begin
         s1_rowxor_ff <= rowxor_in;
         s1_col_ff    <= col_ff;
         s1_first_ff  <= first_ff;
         s1_last_ff   <= in_last;
      end
   end

   // previous row line: written by the prefix stage, read on accept
   always_ff @(posedge clock) begin
      if (s1_valid_ff) begin
         line_mem[s1_col_ff] <= prefix;
      end
      if (in_accept) begin
         mem_q_ff <= line_mem[col_ff];
      end
   end

   // prefix xor of the word in the stage
   assign above  = s1_first_ff ? '0 : (byp_ff ? byp_data_ff : mem_q_ff);
   assign prefix = above ^ s1_rowxor_ff;

   assign out_stage.valid = s1_valid_ff;
   assign out_stage.last  = s1_last_ff;
   assign out_value       = prefix;

endmodule

// ===== sv/pxk_cell.sv =====
// pxk_cell: one slot of the sorted top-k row, keeps or shifts in from its neighbor
// depends on nothing
module pxk_cell #(
   parameter int VALUE_BITS = 20
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  ins,
   input  logic                  clear,
   input  logic [VALUE_BITS-1:0] x,
   input  logic                  prev_keep,
   input  logic                  prev_valid,
   input  logic [VALUE_BITS-1:0] prev_value,
   output logic                  keep,
   output logic                  valid,
   output logic [VALUE_BITS-1:0] value,
   output logic                  valid_in,
   output logic [VALUE_BITS-1:0] value_in
);

   logic                  valid_ff;
   logic [VALUE_BITS-1:0] value_ff;

   // equal values stay ahead of the new one
   assign keep = valid_ff && (value_ff >= x);

   always_comb begin
      priority if (!ins || keep) begin
         valid_in = valid_ff;
         value_in = value_ff;
      end else if (prev_keep) begin
         valid_in = 1'b1;
         value_in = x;
      end else begin
         valid_in = prev_valid;
         value_in = prev_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= clear ? 1'b0 : valid_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign valid = valid_ff;
   assign value = value_ff;

endmodule

// ===== sv/pxk_topk.sv =====
// pxk_topk: row of pxk_cell slots holding the largest values in descending order
// depends on pxk_pkg and pxk_cell
module pxk_topk #(
   parameter int MAX_RANK   = 64,
   parameter int VALUE_BITS = 20
) (
   input  logic                          clock,
   input  logic                          reset,
   input  pxk_pkg::stage_type            ins_stage,
   input  logic [VALUE_BITS-1:0]         ins_value,
   input  logic [pxk_pkg::RANK_K_W-1:0]  rank_k,
   output logic                          res_valid,
   output logic [VALUE_BITS-1:0]         res_value,
   output logic                          res_reached
);

   localparam int IDX_W = (MAX_RANK > 1) ? $clog2(MAX_RANK) : 1;
   localparam int KW    = ($clog2(MAX_RANK + 1) > pxk_pkg::RANK_K_W) ?
                          $clog2(MAX_RANK + 1) : pxk_pkg::RANK_K_W;

   logic                  keep     [MAX_RANK];
   logic                  valid    [MAX_RANK];
   logic [VALUE_BITS-1:0] value    [MAX_RANK];
   logic                  valid_in [MAX_RANK];
   logic [VALUE_BITS-1:0] value_in [MAX_RANK];

   logic                  clear;
   logic [KW-1:0]         k_ext;
   logic [KW-1:0]         k_lim;
   logic [KW-1:0]         k_minus;
   logic [IDX_W-1:0]      idx;

   // the matrix ends after this word goes in
   assign clear = ins_stage.valid && ins_stage.last;

   // chain of cells, the head sees an always-keeping neighbor
   for (genvar i = 0; i < MAX_RANK; i++) begin : g_cell
      if (i == 0) begin : g_head
         pxk_cell #(.VALUE_BITS(VALUE_BITS)) u_cell (
            .clock      (clock),
            .reset      (reset),
            .ins        (ins_stage.valid),
            .clear      (clear),
            .x          (ins_value),
            .prev_keep  (1'b1),
            .prev_valid (1'b1),
            .prev_value (ins_value),
            .keep       (keep[i]),
            .valid      (valid[i]),
            .value      (value[i]),
            .valid_in   (valid_in[i]),
            .value_in   (value_in[i])
         );
      end else begin : g_body
         pxk_cell #(.VALUE_BITS(VALUE_BITS)) u_cell (
            .clock      (clock),
            .reset      (reset),
            .ins        (ins_stage.valid),
            .clear      (clear),
            .x          (ins_value),
            .prev_keep  (keep[i-1]),
            .prev_valid (valid[i-1]),
            .prev_value (value[i-1]),
            .keep       (keep[i]),
            .valid      (valid[i]),
            .value      (value[i]),
            .valid_in   (valid_in[i]),
            .value_in   (value_in[i])
         );
      end
   end

   // clamp rank to 1..MAX_RANK
   assign k_ext = KW'(rank_k);
   always_comb begin
      priority if (k_ext == '0) begin
         k_lim = KW'(1);
      end else if (k_ext > KW'(MAX_RANK)) begin
         k_lim = KW'(MAX_RANK);
      end else begin
         k_lim = k_ext;
      end
   end
   assign k_minus = k_lim - KW'(1);
   assign idx     = k_minus[IDX_W-1:0];

   // pick the k-th slot as it stands after this insertion
   assign res_valid   = clear;
   assign res_reached = valid_in[idx];
   assign res_value   = valid_in[idx] ? value_in[idx] : '0;

endmodule

// ===== sv/pxk_checker.sv =====
// pxk_checker: port-level assertions for prefix_xor_kth_largest, with its bind
// depends on prefix_xor_kth_largest
module pxk_checker #(
   parameter int VALUE_BITS = 20
) (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic                            req_tlast,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [((VALUE_BITS+7)/8)*8-1:0] rsp_tdata,
   input logic                            rsp_tuser
);

   // no result and room for input right after reset
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("block not idle after reset");

   // a stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result word changed");

   // a new result follows an accepted last element
   a_rsp_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(req_tvalid && req_tready && req_tlast, 2))
      else $error("result without a last element");

   // rank not reached reads as zero
   a_rank_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> (rsp_tdata == '0))
      else $error("nonzero value with rank not reached");

endmodule

bind prefix_xor_kth_largest pxk_checker #(.VALUE_BITS(VALUE_BITS)) u_pxk_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tlast  (req_tlast),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
